// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, mode codes and sequencer states of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int TERMINALS_DEF = 3;
  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;

  localparam int MODE_W  = 3;
  localparam int TERM_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int OFFS_W  = 11;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam int HW_POS_MAX = 2047;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RST = 8'd7;

  // register index taken from paddr bit 2
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_ATTR   = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT    = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_MARK   = 3'd3,
    MODE_RETURN = 3'd4,
    MODE_READ   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_RDATA,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Multi-terminal text cell writer: character store in one RAM, cursor and
// command mark per terminal, scroll and clear walked through the RAM.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid/in_stall   | mode, terminal, char, read pos, offset
//  out_     | output    | out_valid/out_stall | cursor, cell, hw cursor, scrolled
//  cfg_     | input     | apb psel/penable    | active terminal, cell attribute
//
//  put, delete, mark, return, bad terminal or read position: exec then done; read: exec, rdata, done
//  scroll copies each row up (one ram copy per cycle), then blanks the last row
//  clear blanks the whole store, one ram write per cycle
//  rate is set by the single write port of the cell ram
//  reset clears cursors, marks and registers; the cell ram is not cleared
//  a result held by out_stall keeps the next request from finishing
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int TERMINALS = tcw_pkg::TERMINALS_DEF,
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS      = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcw_pkg::MODE_W-1:0]    in_mode,
  input  logic [tcw_pkg::TERM_W-1:0]    in_terminal,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::RROW_W-1:0]    in_read_row,
  input  logic [tcw_pkg::RCOL_W-1:0]    in_read_col,
  input  logic [tcw_pkg::OFFS_W-1:0]    in_cursor_offset,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::RCOL_W-1:0]    out_cur_col,
  output logic [tcw_pkg::RROW_W-1:0]    out_cur_row,
  output logic [tcw_pkg::CHAR_W-1:0]    out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]    out_cell_attr,
  output logic [tcw_pkg::OFFS_W-1:0]    out_hw_cursor_pos,
  output logic                          out_scrolled,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [tcw_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [tcw_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int DEPTH  = TERMINALS * CELLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CIW    = $clog2(CELLS + 1);
  localparam int TIW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int HW_LIM = (CELLS - 1 > tcw_pkg::HW_POS_MAX) ? tcw_pkg::HW_POS_MAX : CELLS - 1;

  // sequencer and request registers
  tcw_pkg::state_t state_r, state_nxt;
  logic [tcw_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [TIW-1:0]             t_r, t_nxt;         // terminal the request works on
  logic                       t_ok_r, t_ok_nxt;
  logic [tcw_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [tcw_pkg::RROW_W-1:0] rrow_r, rrow_nxt;
  logic [tcw_pkg::RCOL_W-1:0] rcol_r, rcol_nxt;
  logic [tcw_pkg::OFFS_W-1:0] offs_r, offs_nxt;
  logic [AW-1:0]              base_r, base_nxt;   // first ram word of terminal
  logic                       scr_r, scr_nxt;
  logic [tcw_pkg::CHAR_W-1:0] cchar_r, cchar_nxt;
  logic [tcw_pkg::ATTR_W-1:0] cattr_r, cattr_nxt;
  logic [CIW-1:0]             idx_r, idx_nxt;     // walk position inside store
  logic                       pend_r, pend_nxt;   // copy read in flight
  logic [CIW-1:0]             pidx_r, pidx_nxt;

  // per-terminal cursor and command mark
  logic [CW-1:0] cur_col_r [TERMINALS];
  logic [RW-1:0] cur_row_r [TERMINALS];
  logic [CW-1:0] cmd_col_r [TERMINALS];
  logic [RW-1:0] cmd_row_r [TERMINALS];
  logic [CW-1:0] cur_col_nxt [TERMINALS];
  logic [RW-1:0] cur_row_nxt [TERMINALS];
  logic [CW-1:0] cmd_col_nxt [TERMINALS];
  logic [RW-1:0] cmd_row_nxt [TERMINALS];

  // configuration
  logic [TIW-1:0]             active_r, active_nxt;
  logic [tcw_pkg::ATTR_W-1:0] attr_r, attr_nxt;

  // result register
  logic                       ovalid_r, ovalid_nxt;
  logic [tcw_pkg::RCOL_W-1:0] ocol_r, ocol_nxt;
  logic [tcw_pkg::RROW_W-1:0] orow_r, orow_nxt;
  logic [tcw_pkg::CHAR_W-1:0] ochar_r, ochar_nxt;
  logic [tcw_pkg::ATTR_W-1:0] oattr_r, oattr_nxt;
  logic [tcw_pkg::OFFS_W-1:0] opos_r, opos_nxt;
  logic                       oscr_r, oscr_nxt;

  // cell ram ports
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic                       cfg_wr;
  logic                       accept;
  logic [tcw_pkg::TERM_W-1:0] sel_term;
  logic                       nl;
  int                         hw_pos;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall   = (state_r != tcw_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  assign out_valid         = ovalid_r;
  assign out_cur_col       = ocol_r;
  assign out_cur_row       = orow_r;
  assign out_cell_char     = ochar_r;
  assign out_cell_attr     = oattr_r;
  assign out_hw_cursor_pos = opos_r;
  assign out_scrolled      = oscr_r;

  always_comb begin
    if (cfg_paddr[2] == tcw_pkg::REG_ACTIVE) begin
      cfg_prdata = tcw_pkg::DATA_W'(active_r);
    end else begin
      cfg_prdata = tcw_pkg::DATA_W'(attr_r);
    end
  end

  // delete, clear and return work on the active terminal, the rest on the field
  always_comb begin
    if (in_mode == tcw_pkg::MODE_DELETE || in_mode == tcw_pkg::MODE_CLEAR ||
        in_mode == tcw_pkg::MODE_RETURN) begin
      sel_term = tcw_pkg::TERM_W'(active_r);
    end else begin
      sel_term = in_terminal;
    end
  end

  assign nl = (ch_r == tcw_pkg::CH_NL) || (ch_r == tcw_pkg::CH_CR);

  // hardware cursor from the active command mark, saturated
  always_comb begin
    hw_pos = int'(cmd_row_r[active_r]) * COLUMNS + int'(cmd_col_r[active_r]) + int'(offs_r);
    if (hw_pos > HW_LIM) begin
      hw_pos = HW_LIM;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    t_nxt       = t_r;
    t_ok_nxt    = t_ok_r;
    ch_nxt      = ch_r;
    rrow_nxt    = rrow_r;
    rcol_nxt    = rcol_r;
    offs_nxt    = offs_r;
    base_nxt    = base_r;
    scr_nxt     = scr_r;
    cchar_nxt   = cchar_r;
    cattr_nxt   = cattr_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    pidx_nxt    = pidx_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    cmd_col_nxt = cmd_col_r;
    cmd_row_nxt = cmd_row_r;
    active_nxt  = active_r;
    attr_nxt    = attr_r;
    ovalid_nxt  = ovalid_r;
    ocol_nxt    = ocol_r;
    orow_nxt    = orow_r;
    ochar_nxt   = ochar_r;
    oattr_nxt   = oattr_r;
    opos_nxt    = opos_r;
    oscr_nxt    = oscr_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = base_r;
    ram_raddr   = base_r;
    ram_wdata   = {attr_r, tcw_pkg::CH_BLANK};

    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end

    // register writes; an out-of-range terminal number is dropped
    if (cfg_wr) begin
      if (cfg_paddr[2] == tcw_pkg::REG_ACTIVE) begin
        if (int'(cfg_pwdata[1:0]) < TERMINALS) begin
          active_nxt = TIW'(cfg_pwdata[1:0]);
        end
      end else begin
        attr_nxt = cfg_pwdata[tcw_pkg::ATTR_W-1:0];
      end
    end

    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          mode_nxt  = in_mode;
          t_nxt     = TIW'(sel_term);
          t_ok_nxt  = int'(sel_term) < TERMINALS;
          base_nxt  = AW'(int'(sel_term) * CELLS);
          ch_nxt    = in_char_code;
          rrow_nxt  = in_read_row;
          rcol_nxt  = in_read_col;
          offs_nxt  = in_cursor_offset;
          scr_nxt   = 1'b0;
          cchar_nxt = '0;
          cattr_nxt = '0;
          state_nxt = tcw_pkg::ST_EXEC;
        end
      end

      tcw_pkg::ST_EXEC: begin
        state_nxt = tcw_pkg::ST_DONE;
        ram_waddr = AW'(int'(base_r) + int'(cur_row_r[t_r]) * COLUMNS + int'(cur_col_r[t_r]));
        if (t_ok_r) begin
          unique case (mode_r)
            tcw_pkg::MODE_PUT: begin
              if (nl) begin
                cur_col_nxt[t_r] = '0;
                if (int'(cur_row_r[t_r]) < ROWS - 1) begin
                  cur_row_nxt[t_r] = RW'(cur_row_r[t_r] + 1'b1);
                end else begin
                  // scroll at column zero pulls the mark up one row
                  if (cur_col_r[t_r] == '0 && cmd_row_r[t_r] != '0) begin
                    cmd_row_nxt[t_r] = RW'(cmd_row_r[t_r] - 1'b1);
                  end
                  scr_nxt   = 1'b1;
                  idx_nxt   = CIW'(COLUMNS);
                  pend_nxt  = 1'b0;
                  state_nxt = tcw_pkg::ST_SCROLL;
                end
              end else begin
                ram_we    = 1'b1;
                ram_wdata = {attr_r, ch_r};
                if (ch_r != tcw_pkg::CH_NUL) begin
                  if (int'(cur_col_r[t_r]) == COLUMNS - 1) begin
                    cur_col_nxt[t_r] = '0;
                    if (int'(cur_row_r[t_r]) < ROWS - 1) begin
                      cur_row_nxt[t_r] = RW'(cur_row_r[t_r] + 1'b1);
                    end else begin
                      if (cmd_row_r[t_r] != '0) begin
                        cmd_row_nxt[t_r] = RW'(cmd_row_r[t_r] - 1'b1);
                      end
                      scr_nxt   = 1'b1;
                      idx_nxt   = CIW'(COLUMNS);
                      pend_nxt  = 1'b0;
                      state_nxt = tcw_pkg::ST_SCROLL;
                    end
                  end else begin
                    cur_col_nxt[t_r] = CW'(cur_col_r[t_r] + 1'b1);
                  end
                end
              end
            end
            tcw_pkg::MODE_DELETE: begin
              ram_we = 1'b1;
              if (cur_col_r[t_r] == '0) begin
                if (cur_row_r[t_r] != '0) begin
                  cur_col_nxt[t_r] = CW'(COLUMNS - 1);
                  cur_row_nxt[t_r] = RW'(cur_row_r[t_r] - 1'b1);
                end
              end else begin
                cur_col_nxt[t_r] = CW'(cur_col_r[t_r] - 1'b1);
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              cur_col_nxt[t_r] = '0;
              cur_row_nxt[t_r] = '0;
              cmd_col_nxt[t_r] = '0;
              cmd_row_nxt[t_r] = '0;
              idx_nxt          = '0;
              state_nxt        = tcw_pkg::ST_BLANK;
            end
            tcw_pkg::MODE_MARK: begin
              cmd_col_nxt[t_r] = cur_col_r[t_r];
              cmd_row_nxt[t_r] = cur_row_r[t_r];
            end
            tcw_pkg::MODE_RETURN: begin
              cur_col_nxt[t_r] = cmd_col_r[t_r];
              cur_row_nxt[t_r] = cmd_row_r[t_r];
            end
            tcw_pkg::MODE_READ: begin
              if (int'(rrow_r) < ROWS && int'(rcol_r) < COLUMNS) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(int'(base_r) + int'(rrow_r) * COLUMNS + int'(rcol_r));
                state_nxt = tcw_pkg::ST_RDATA;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // copy row r+1 to row r, one word per cycle, each read running ahead of its write
      tcw_pkg::ST_SCROLL: begin
        if (idx_r != CIW'(CELLS)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(int'(base_r) + int'(idx_r));
          idx_nxt   = CIW'(idx_r + 1'b1);
        end
        pend_nxt = (idx_r != CIW'(CELLS));
        pidx_nxt = CIW'(idx_r - CIW'(COLUMNS));
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(int'(base_r) + int'(pidx_r));
          ram_wdata = ram_rdata;
        end
        if (idx_r == CIW'(CELLS) && !pend_r) begin
          idx_nxt   = CIW'((ROWS - 1) * COLUMNS);
          state_nxt = tcw_pkg::ST_BLANK;
        end
      end

      // blank words from idx to the end of the store
      tcw_pkg::ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(int'(base_r) + int'(idx_r));
        idx_nxt   = CIW'(idx_r + 1'b1);
        if (idx_r == CIW'(CELLS - 1)) begin
          state_nxt = tcw_pkg::ST_DONE;
        end
      end

      tcw_pkg::ST_RDATA: begin
        cchar_nxt = ram_rdata[tcw_pkg::CHAR_W-1:0];
        cattr_nxt = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        state_nxt = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_DONE: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          if (t_ok_r) begin
            ocol_nxt = tcw_pkg::RCOL_W'(cur_col_r[t_r]);
            orow_nxt = tcw_pkg::RROW_W'(cur_row_r[t_r]);
          end else begin
            ocol_nxt = '0;
            orow_nxt = '0;
          end
          ochar_nxt = cchar_r;
          oattr_nxt = cattr_r;
          opos_nxt  = tcw_pkg::OFFS_W'(hw_pos);
          oscr_nxt  = scr_r;
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tcw_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      active_r <= '0;
      attr_r   <= tcw_pkg::ATTR_RST;
      pend_r   <= 1'b0;
      for (int i = 0; i < TERMINALS; i++) begin
        cur_col_r[i] <= '0;
        cur_row_r[i] <= '0;
        cmd_col_r[i] <= '0;
        cmd_row_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      active_r  <= active_nxt;
      attr_r    <= attr_nxt;
      pend_r    <= pend_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      cmd_col_r <= cmd_col_nxt;
      cmd_row_r <= cmd_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    t_r     <= t_nxt;
    t_ok_r  <= t_ok_nxt;
    ch_r    <= ch_nxt;
    rrow_r  <= rrow_nxt;
    rcol_r  <= rcol_nxt;
    offs_r  <= offs_nxt;
    base_r  <= base_nxt;
    scr_r   <= scr_nxt;
    cchar_r <= cchar_nxt;
    cattr_r <= cattr_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    ocol_r  <= ocol_nxt;
    orow_r  <= orow_nxt;
    ochar_r <= ochar_nxt;
    oattr_r <= oattr_nxt;
    opos_r  <= opos_nxt;
    oscr_r  <= oscr_nxt;
  end

endmodule

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== verif/text_console_writer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the request, result and register ports of the console writer,
// keeps its own copy of the terminal stores and cursors, and compares
// every result with the predicted one in order.
// ----------------------------------------------------------------------------
module text_console_writer_checker
  import tcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [TERM_W-1:0]   in_terminal,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic [RROW_W-1:0]   in_read_row,
  input  logic [RCOL_W-1:0]   in_read_col,
  input  logic [OFFS_W-1:0]   in_cursor_offset,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [RCOL_W-1:0]   out_cur_col,
  input  logic [RROW_W-1:0]   out_cur_row,
  input  logic [CHAR_W-1:0]   out_cell_char,
  input  logic [ATTR_W-1:0]   out_cell_attr,
  input  logic [OFFS_W-1:0]   out_hw_cursor_pos,
  input  logic                out_scrolled,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [PADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]   cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  pending
);

  localparam int NT    = TERMINALS_DEF;
  localparam int NC    = COLUMNS_DEF;
  localparam int NR    = ROWS_DEF;
  localparam int CELLS = NR * NC;

  typedef struct packed {
    logic [RCOL_W-1:0] col;
    logic [RROW_W-1:0] row;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] at;
    logic [OFFS_W-1:0] hw;
    logic              scr;
  } console_result_t;

  logic [CELL_W-1:0] screen [NT][CELLS];
  int                crs_col [NT];
  int                crs_row [NT];
  int                mark_col [NT];
  int                mark_row [NT];
  int                shown_term;
  logic [ATTR_W-1:0] attr_reg;
  logic              scroll_flag;

  console_result_t   expected_results [$];

  assign pending = expected_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic blank_at(input int t, input int p);
    screen[t][p] = {attr_reg, CH_BLANK};
  endtask

  task automatic scroll_screen(input int t);
    if (crs_col[t] == 0 && crs_row[t] == NR - 1 && mark_row[t] > 0)
      mark_row[t]--;
    for (int p = 0; p < (NR - 1) * NC; p++)
      screen[t][p] = screen[t][p + NC];
    for (int c = 0; c < NC; c++)
      blank_at(t, (NR - 1) * NC + c);
    scroll_flag = 1'b1;
  endtask

  task automatic next_line(input int t);
    if (crs_row[t] < NR - 1)
      crs_row[t]++;
    else
      scroll_screen(t);
  endtask

  task automatic write_char(input int t, input logic [CHAR_W-1:0] ch);
    if (ch == CH_NL || ch == CH_CR) begin
      next_line(t);
      crs_col[t] = 0;
    end else begin
      screen[t][crs_row[t] * NC + crs_col[t]] = {attr_reg, ch};
      if (ch != CH_NUL) begin
        crs_col[t]++;
        if (crs_col[t] > NC - 1) begin
          crs_col[t] = 0;
          next_line(t);
        end
      end
    end
  endtask

  task automatic predict_request();
    int              a;
    int              rep;
    int              t;
    int              pos;
    bit              term_ok;
    console_result_t r;
    a = shown_term;
    t = int'(in_terminal);
    rep = t;
    term_ok = t < NT;
    r = '0;
    scroll_flag = 1'b0;
    case (in_mode)
      MODE_PUT: begin
        if (term_ok) write_char(t, in_char_code);
      end
      MODE_DELETE: begin
        rep = a;
        blank_at(a, crs_row[a] * NC + crs_col[a]);
        if (crs_col[a] == 0) begin
          if (crs_row[a] != 0) begin
            crs_col[a] = NC - 1;
            crs_row[a]--;
          end
        end else begin
          crs_col[a]--;
        end
      end
      MODE_CLEAR: begin
        rep = a;
        for (int p = 0; p < CELLS; p++) blank_at(a, p);
        crs_col[a] = 0;
        crs_row[a] = 0;
        mark_col[a] = 0;
        mark_row[a] = 0;
      end
      MODE_MARK: begin
        if (term_ok) begin
          mark_col[t] = crs_col[t];
          mark_row[t] = crs_row[t];
        end
      end
      MODE_RETURN: begin
        rep = a;
        crs_col[a] = mark_col[a];
        crs_row[a] = mark_row[a];
      end
      MODE_READ: begin
        if (term_ok && in_read_row < NR && in_read_col < NC)
          {r.at, r.ch} = screen[t][int'(in_read_row) * NC + int'(in_read_col)];
      end
      default: ;
    endcase
    pos = mark_row[a] * NC + mark_col[a] + int'(in_cursor_offset);
    if (pos > CELLS - 1) pos = CELLS - 1;
    if (pos > HW_POS_MAX) pos = HW_POS_MAX;
    if (rep < NT) begin
      r.col = RCOL_W'(crs_col[rep]);
      r.row = RROW_W'(crs_row[rep]);
    end
    r.hw  = OFFS_W'(pos);
    r.scr = scroll_flag;
    expected_results.push_back(r);
  endtask

  task automatic compare_result();
    console_result_t w;
    if (expected_results.size() == 0) begin
      report("unexpected result", 1, 0);
    end else begin
      w = expected_results.pop_front();
      if (out_cur_col != w.col) report("cur_col", int'(out_cur_col), int'(w.col));
      if (out_cur_row != w.row) report("cur_row", int'(out_cur_row), int'(w.row));
      if (out_cell_char != w.ch) report("cell_char", int'(out_cell_char), int'(w.ch));
      if (out_cell_attr != w.at) report("cell_attr", int'(out_cell_attr), int'(w.at));
      if (out_hw_cursor_pos != w.hw)
        report("hw_cursor_pos", int'(out_hw_cursor_pos), int'(w.hw));
      if (out_scrolled != w.scr) report("scrolled", int'(out_scrolled), int'(w.scr));
    end
  endtask

  initial begin
    fail_count = 0;
    shown_term = 0;
    attr_reg = ATTR_RST;
    for (int t = 0; t < NT; t++) begin
      crs_col[t] = 0;
      crs_row[t] = 0;
      mark_col[t] = 0;
      mark_row[t] = 0;
      for (int p = 0; p < CELLS; p++) screen[t][p] = '0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) compare_result();
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_ACTIVE) begin
          if (int'(cfg_pwdata[1:0]) < NT) shown_term = int'(cfg_pwdata[1:0]);
        end else begin
          attr_reg = cfg_pwdata[ATTR_W-1:0];
        end
      end
      if (in_valid && !in_stall) predict_request();
    end
  end

endmodule

// ===== verif/text_console_writer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives requests and register writes into the console writer with random
// gaps and result stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  // spare mode codes the block must treat as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam logic [PADDR_W-1:0] ADDR_ACTIVE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_ATTR   = 3'd4;
  localparam int DRAIN_CYCLES = 20;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [TERM_W-1:0]   in_terminal;
  logic [CHAR_W-1:0]   in_char_code;
  logic [RROW_W-1:0]   in_read_row;
  logic [RCOL_W-1:0]   in_read_col;
  logic [OFFS_W-1:0]   in_cursor_offset;
  logic                out_valid;
  logic                out_stall;
  logic [RCOL_W-1:0]   out_cur_col;
  logic [RROW_W-1:0]   out_cur_row;
  logic [CHAR_W-1:0]   out_cell_char;
  logic [ATTR_W-1:0]   out_cell_attr;
  logic [OFFS_W-1:0]   out_hw_cursor_pos;
  logic                out_scrolled;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [PADDR_W-1:0]  cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  int fail_count;
  int pending;

  // when set, neither side idles (back-to-back stretches)
  bit no_gaps;

  // per-phase knobs for the random request mix
  int nl_pct;
  int clr_pct;

  text_console_writer i_dut (.*);

  text_console_writer_checker i_checker (.*);

  // clock, 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall limit: far above the slowest legal run
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall before each result, none when no_gaps is set
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      // wait for the result to be taken at the coming rising edge
      #1;
      while (!out_valid) begin
        @(negedge clk);
        #1;
      end
      @(negedge clk);
    end
  end

  // one request: idle gap, then hold valid until the block takes it
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [TERM_W-1:0] term,
                              input logic [CHAR_W-1:0] ch, input logic [RROW_W-1:0] rrow,
                              input logic [RCOL_W-1:0] rcol, input logic [OFFS_W-1:0] offs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_terminal      <= term;
    in_char_code     <= ch;
    in_read_row      <= rrow;
    in_read_col      <= rcol;
    in_cursor_offset <= offs;
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // sender holds off until every predicted result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one random request drawn from the phase mix
  task automatic random_request();
    int                  pick;
    logic [MODE_W-1:0]   mode;
    logic [TERM_W-1:0]   term;
    logic [CHAR_W-1:0]   ch;
    logic [RROW_W-1:0]   rrow;
    logic [RCOL_W-1:0]   rcol;
    logic [OFFS_W-1:0]   offs;
    pick = $urandom_range(0, 99);
    if (pick < 60)                 mode = MODE_PUT;
    else if (pick < 68)            mode = MODE_DELETE;
    else if (pick < 68 + clr_pct)  mode = MODE_CLEAR;
    else if (pick < 75)            mode = MODE_MARK;
    else if (pick < 82)            mode = MODE_RETURN;
    else if (pick < 98)            mode = MODE_READ;
    else                           mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
    // mostly one terminal so lines fill up; bad terminal now and then
    pick = $urandom_range(0, 99);
    if (pick < 3)        term = 2'd3;
    else if (pick < 60)  term = 2'd0;
    else                 term = TERM_W'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < nl_pct)            ch = CH_NL;
    else if (pick < nl_pct + 3)   ch = CH_CR;
    else if (pick < nl_pct + 6)   ch = CH_NUL;
    else                          ch = CHAR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      rrow = RROW_W'($urandom());
      rcol = RCOL_W'($urandom());
    end else begin
      rrow = RROW_W'($urandom_range(0, ROWS_DEF - 1));
      rcol = RCOL_W'($urandom_range(0, COLUMNS_DEF - 1));
    end
    offs = $urandom_range(0, 3) == 0 ? OFFS_W'($urandom()) : OFFS_W'($urandom_range(0, 40));
    send_request(mode, term, ch, rrow, rcol, offs);
  endtask

  initial begin
    int a_val;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = MODE_PUT;
    in_terminal      = '0;
    in_char_code     = '0;
    in_read_row      = '0;
    in_read_col      = '0;
    in_cursor_offset = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    no_gaps          = 1'b0;
    nl_pct           = 8;
    clr_pct          = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // every store is blank before anything reads it
    for (int t = TERMINALS_DEF - 1; t >= 0; t--) begin
      write_reg(ADDR_ACTIVE, DATA_W'(t));
      send_request(MODE_CLEAR, 2'd0, 8'd0, 5'd0, 7'd0, 11'd0);
      wait_idle();
    end

    // directed: terminal 0 is active, attribute at its extreme
    write_reg(ADDR_ATTR, 32'hFF);
    // delete at home blanks but keeps the cursor
    send_request(MODE_DELETE, 2'd0, 8'd0, 5'd0, 7'd0, 11'd0);
    send_request(MODE_PUT, 2'd0, 8'd65, 5'd0, 7'd0, 11'd0);
    send_request(MODE_PUT, 2'd0, 8'd255, 5'd0, 7'd0, 11'd2047);
    send_request(MODE_PUT, 2'd0, CH_NUL, 5'd0, 7'd0, 11'd0);
    send_request(MODE_READ, 2'd0, 8'd0, 5'd0, 7'd1, 11'd0);
    send_request(MODE_READ, 2'd0, 8'd0, 5'd0, 7'd2, 11'd0);
    send_request(MODE_PUT, 2'd0, CH_NL, 5'd0, 7'd0, 11'd1999);
    send_request(MODE_PUT, 2'd1, CH_CR, 5'd0, 7'd0, 11'd0);
    send_request(MODE_MARK, 2'd0, 8'd0, 5'd0, 7'd0, 11'd0);
    send_request(MODE_PUT, 2'd0, 8'd66, 5'd0, 7'd0, 11'd0);
    send_request(MODE_RETURN, 2'd0, 8'd0, 5'd0, 7'd0, 11'd5);
    // bad terminal field does nothing
    send_request(MODE_PUT, 2'd3, 8'd67, 5'd0, 7'd0, 11'd0);
    send_request(MODE_MARK, 2'd3, 8'd0, 5'd0, 7'd0, 11'd0);
    send_request(MODE_READ, 2'd3, 8'd0, 5'd0, 7'd0, 11'd0);
    // read positions outside the screen and at its last cell, then the spare mode codes
    send_request(MODE_READ, 2'd0, 8'd0, 5'd25, 7'd0, 11'd0);
    send_request(MODE_READ, 2'd2, 8'd0, 5'd24, 7'd80, 11'd0);
    send_request(MODE_READ, 2'd1, 8'd0, 5'd31, 7'd127, 11'd0);
    send_request(MODE_READ, 2'd2, 8'd0, 5'd24, 7'd79, 11'd0);
    send_request(MODE_SPARE_A, 2'd2, 8'd255, 5'd31, 7'd127, 11'd2047);
    send_request(MODE_SPARE_B, 2'd1, 8'd0, 5'd0, 7'd0, 11'd0);
    // delete wraps back to column 79 of the previous row
    send_request(MODE_DELETE, 2'd0, 8'd0, 5'd0, 7'd0, 11'd0);
    send_request(MODE_DELETE, 2'd0, 8'd0, 5'd0, 7'd0, 11'd0);
    wait_idle();
    // out-of-range active value is ignored
    write_reg(ADDR_ACTIVE, 32'd3);
    write_reg(ADDR_ATTR, 32'h00);
    send_request(MODE_PUT, 2'd0, 8'd68, 5'd0, 7'd0, 11'd0);
    send_request(MODE_READ, 2'd0, 8'd0, 5'd1, 7'd1, 11'd0);

    // random phases, each with its own register setting and mix
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: a_val = 0;
        1: a_val = 2;
        2: a_val = 3;
        default: a_val = $urandom_range(0, 3);
      endcase
      write_reg(ADDR_ACTIVE, DATA_W'(a_val));
      write_reg(ADDR_ATTR, ph == 1 ? 32'hFF : ph == 2 ? 32'h00 : $urandom_range(0, 255));
      no_gaps = (ph == 3);
      // some phases run long lines to reach wrap, others many line breaks to scroll
      nl_pct  = (ph % 3 == 0) ? 1 : (ph % 3 == 1) ? 20 : 8;
      clr_pct = (ph % 3 == 1) ? 0 : 1;
      for (int k = 0; k < 105; k++) random_request();
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
